@@ design/ipv4rf_pkg.sv @@
package ipv4rf_pkg;

    // Frame layout
    localparam logic [15:0] ETH_HDR_BYTES   = 16'd14;
    localparam logic [15:0] MIN_FRAME_BYTES = 16'd34;
    localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
    localparam logic [31:0] BCAST_ADDR      = 32'hFFFF_FFFF;
    localparam logic [13:0] FRAG_NONE       = 14'd0;
    localparam logic [3:0]  IP_VERSION_4    = 4'd4;
    localparam logic [3:0]  IHL_MIN         = 4'd5;
    localparam logic [7:0]  TTL_MIN         = 8'd1;

    // IPv4 header byte offsets, and frame positions of the EtherType bytes
    localparam logic [15:0] OFF_VER_IHL  = 16'd0;
    localparam logic [15:0] OFF_TLEN_HI  = 16'd2;
    localparam logic [15:0] OFF_TLEN_LO  = 16'd3;
    localparam logic [15:0] OFF_FLAG_HI  = 16'd6;
    localparam logic [15:0] OFF_FLAG_LO  = 16'd7;
    localparam logic [15:0] OFF_TTL      = 16'd8;
    localparam logic [15:0] OFF_PROTO    = 16'd9;
    localparam logic [15:0] OFF_CSUM_HI  = 16'd10;
    localparam logic [15:0] OFF_CSUM_LO  = 16'd11;
    localparam logic [15:0] OFF_SRC      = 16'd12;
    localparam logic [15:0] OFF_DST      = 16'd16;
    localparam logic [15:0] OFF_HDR_END  = 16'd20;
    localparam logic [15:0] POS_ETYPE_HI = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO = 16'd13;

    // Verdict codes
    localparam logic [3:0] VERDICT_ACCEPT    = 4'd0;
    localparam logic [3:0] VERDICT_SHORT_ETH = 4'd1;
    localparam logic [3:0] VERDICT_ETHERTYPE = 4'd2;
    localparam logic [3:0] VERDICT_SHORT_IP  = 4'd3;
    localparam logic [3:0] VERDICT_VERSION   = 4'd4;
    localparam logic [3:0] VERDICT_IHL       = 4'd5;
    localparam logic [3:0] VERDICT_LENGTH    = 4'd6;
    localparam logic [3:0] VERDICT_CHECKSUM  = 4'd7;
    localparam logic [3:0] VERDICT_TTL       = 4'd8;
    localparam logic [3:0] VERDICT_ADDRESS   = 4'd9;
    localparam logic [3:0] VERDICT_FRAGMENT  = 4'd10;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  verdict;
        logic [7:0]  protocol;
        logic [5:0]  header_length;
        logic [15:0] payload_length;
        logic [31:0] source_address;
        logic [31:0] destination_address;
    } out_item_t;

    // Everything captured from one frame, handed from front to back
    typedef struct packed {
        logic [15:0] frame_length;
        logic [15:0] ether_type;
        logic [7:0]  version_ihl;
        logic [15:0] total_length;
        logic [15:0] flags_offset;
        logic [7:0]  time_to_live;
        logic [7:0]  protocol;
        logic [15:0] received_checksum;
        logic [15:0] checksum_sum;
        logic [31:0] source;
        logic [31:0] destination;
    } frame_sum_t;

endpackage

@@ design/ipv4rf_front.sv @@
module ipv4rf_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  ipv4rf_pkg::in_item_t    s_item,
    output logic                    push_valid,
    input  logic                    push_ready,
    output ipv4rf_pkg::frame_sum_t  push_data
);

    logic [15:0] byte_count_reg, byte_count_next;
    logic [15:0] ether_type_reg, ether_type_next;
    logic [7:0]  version_ihl_reg, version_ihl_next;
    logic [15:0] total_length_reg, total_length_next;
    logic [15:0] flags_offset_reg, flags_offset_next;
    logic [7:0]  ttl_reg, ttl_next;
    logic [7:0]  protocol_reg, protocol_next;
    logic [15:0] rx_csum_reg, rx_csum_next;
    logic [15:0] csum_sum_reg, csum_sum_next;
    logic [7:0]  high_hold_reg, high_hold_next;
    logic [31:0] source_reg, source_next;
    logic [31:0] dest_reg, dest_next;

    logic [7:0]  b;
    logic [7:0]  csum_byte;
    logic [15:0] pos;
    logic [15:0] off;
    logic        take;
    logic        in_ip;
    logic        in_hdr;
    logic [5:0]  hdr_len;
    logic [16:0] csum_wide;
    logic        accept;

    assign s_ready    = push_ready;
    assign accept     = s_valid && s_ready;
    assign push_valid = s_valid && s_item.last_byte;

    // Capture fields and fold header words into the running sum
    always_comb begin
        b                 = s_item.frame_byte;
        pos               = byte_count_reg;
        off               = pos - ipv4rf_pkg::ETH_HDR_BYTES;
        take              = (pos != ipv4rf_pkg::COUNT_MAX);
        in_ip             = (pos >= ipv4rf_pkg::ETH_HDR_BYTES);

        byte_count_next   = take ? pos + 16'd1 : pos;
        ether_type_next   = ether_type_reg;
        version_ihl_next  = version_ihl_reg;
        total_length_next = total_length_reg;
        flags_offset_next = flags_offset_reg;
        ttl_next          = ttl_reg;
        protocol_next     = protocol_reg;
        rx_csum_next      = rx_csum_reg;
        csum_sum_next     = csum_sum_reg;
        high_hold_next    = high_hold_reg;
        source_next       = source_reg;
        dest_next         = dest_reg;

        if (take && pos == ipv4rf_pkg::POS_ETYPE_HI) begin
            ether_type_next = {b, 8'h00};
        end
        if (take && pos == ipv4rf_pkg::POS_ETYPE_LO) begin
            ether_type_next = {ether_type_reg[15:8], b};
        end

        if (take && in_ip) begin
            if (off == ipv4rf_pkg::OFF_VER_IHL) begin
                version_ihl_next = b;
            end
            if (off == ipv4rf_pkg::OFF_TLEN_HI) begin
                total_length_next = {b, 8'h00};
            end
            if (off == ipv4rf_pkg::OFF_TLEN_LO) begin
                total_length_next = {total_length_reg[15:8], b};
            end
            if (off == ipv4rf_pkg::OFF_FLAG_HI) begin
                flags_offset_next = {b, 8'h00};
            end
            if (off == ipv4rf_pkg::OFF_FLAG_LO) begin
                flags_offset_next = {flags_offset_reg[15:8], b};
            end
            if (off == ipv4rf_pkg::OFF_TTL) begin
                ttl_next = b;
            end
            if (off == ipv4rf_pkg::OFF_PROTO) begin
                protocol_next = b;
            end
            if (off == ipv4rf_pkg::OFF_CSUM_HI) begin
                rx_csum_next = {b, 8'h00};
            end
            if (off == ipv4rf_pkg::OFF_CSUM_LO) begin
                rx_csum_next = {rx_csum_reg[15:8], b};
            end
            if (off >= ipv4rf_pkg::OFF_SRC && off < ipv4rf_pkg::OFF_DST) begin
                source_next = {source_reg[23:0], b};
            end
            if (off >= ipv4rf_pkg::OFF_DST && off < ipv4rf_pkg::OFF_HDR_END) begin
                dest_next = {dest_reg[23:0], b};
            end
        end

        // Header length follows the version/IHL byte of this very step
        hdr_len   = {version_ihl_next[3:0], 2'b00};
        in_hdr    = take && in_ip && (off < {10'd0, hdr_len});
        csum_byte = (off == ipv4rf_pkg::OFF_CSUM_HI || off == ipv4rf_pkg::OFF_CSUM_LO)
                    ? 8'h00 : b;
        csum_wide = {1'b0, csum_sum_reg} + {1'b0, high_hold_reg, csum_byte};
        if (in_hdr) begin
            if (!off[0]) begin
                high_hold_next = csum_byte;
            end else begin
                csum_sum_next = csum_wide[15:0] + {15'd0, csum_wide[16]};
            end
        end
    end

    // Hand the finished frame to the queue
    always_comb begin
        push_data.frame_length      = byte_count_next;
        push_data.ether_type        = ether_type_next;
        push_data.version_ihl       = version_ihl_next;
        push_data.total_length      = total_length_next;
        push_data.flags_offset      = flags_offset_next;
        push_data.time_to_live      = ttl_next;
        push_data.protocol          = protocol_next;
        push_data.received_checksum = rx_csum_next;
        push_data.checksum_sum      = csum_sum_next;
        push_data.source            = source_next;
        push_data.destination       = dest_next;
    end

    // Advance per accepted item; clear on reset and after the last byte of a frame
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_item.last_byte)) begin
            byte_count_reg   <= '0;
            ether_type_reg   <= '0;
            version_ihl_reg  <= '0;
            total_length_reg <= '0;
            flags_offset_reg <= '0;
            ttl_reg          <= '0;
            protocol_reg     <= '0;
            rx_csum_reg      <= '0;
            csum_sum_reg     <= '0;
            high_hold_reg    <= '0;
            source_reg       <= '0;
            dest_reg         <= '0;
        end else if (accept) begin
            byte_count_reg   <= byte_count_next;
            ether_type_reg   <= ether_type_next;
            version_ihl_reg  <= version_ihl_next;
            total_length_reg <= total_length_next;
            flags_offset_reg <= flags_offset_next;
            ttl_reg          <= ttl_next;
            protocol_reg     <= protocol_next;
            rx_csum_reg      <= rx_csum_next;
            csum_sum_reg     <= csum_sum_next;
            high_hold_reg    <= high_hold_next;
            source_reg       <= source_next;
            dest_reg         <= dest_next;
        end
    end

endmodule

@@ design/ipv4rf_queue.sv @@
module ipv4rf_queue #(
    parameter int DEPTH = 2
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    wr_valid,
    output logic                    wr_ready,
    input  ipv4rf_pkg::frame_sum_t  wr_data,
    output logic                    rd_valid,
    input  logic                    rd_ready,
    output ipv4rf_pkg::frame_sum_t  rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ipv4rf_pkg::frame_sum_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Wrap pointers and track the fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the frame summary
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ design/ipv4rf_back.sv @@
module ipv4rf_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [31:0]             cfg_wdata,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  ipv4rf_pkg::frame_sum_t  pop_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output ipv4rf_pkg::out_item_t   m_item
);

    logic [31:0]           local_addr_reg;
    logic                  out_valid_reg;
    ipv4rf_pkg::out_item_t out_item_reg;
    ipv4rf_pkg::out_item_t out_item_next;

    logic [15:0] ip_len;
    logic [15:0] hdr_len16;
    logic [5:0]  hdr_len;

    assign pop_ready = !out_valid_reg || m_ready;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_item_reg;

    // Run the checks in order; the first failure wins
    always_comb begin
        hdr_len   = {pop_data.version_ihl[3:0], 2'b00};
        hdr_len16 = {10'd0, hdr_len};
        ip_len    = pop_data.frame_length - ipv4rf_pkg::ETH_HDR_BYTES;

        out_item_next.protocol            = pop_data.protocol;
        out_item_next.header_length       = hdr_len;
        out_item_next.source_address      = pop_data.source;
        out_item_next.destination_address = pop_data.destination;
        out_item_next.payload_length      = '0;

        if (pop_data.frame_length < ipv4rf_pkg::ETH_HDR_BYTES) begin
            out_item_next.verdict = ipv4rf_pkg::VERDICT_SHORT_ETH;
        end else if (pop_data.ether_type != ipv4rf_pkg::ETHERTYPE_IPV4) begin
            out_item_next.verdict = ipv4rf_pkg::VERDICT_ETHERTYPE;
        end else if (pop_data.frame_length < ipv4rf_pkg::MIN_FRAME_BYTES) begin
            out_item_next.verdict = ipv4rf_pkg::VERDICT_SHORT_IP;
        end else if (pop_data.version_ihl[7:4] != ipv4rf_pkg::IP_VERSION_4) begin
            out_item_next.verdict = ipv4rf_pkg::VERDICT_VERSION;
        end else if (pop_data.version_ihl[3:0] < ipv4rf_pkg::IHL_MIN
                     || hdr_len16 > ip_len) begin
            out_item_next.verdict = ipv4rf_pkg::VERDICT_IHL;
        end else if (pop_data.total_length > ip_len
                     || pop_data.total_length < hdr_len16) begin
            out_item_next.verdict = ipv4rf_pkg::VERDICT_LENGTH;
        end else if (~pop_data.checksum_sum != pop_data.received_checksum) begin
            out_item_next.verdict = ipv4rf_pkg::VERDICT_CHECKSUM;
        end else if (pop_data.time_to_live <= ipv4rf_pkg::TTL_MIN) begin
            out_item_next.verdict = ipv4rf_pkg::VERDICT_TTL;
        end else if (pop_data.destination != local_addr_reg
                     && pop_data.destination != ipv4rf_pkg::BCAST_ADDR) begin
            out_item_next.verdict = ipv4rf_pkg::VERDICT_ADDRESS;
        end else if (pop_data.flags_offset[13:0] != ipv4rf_pkg::FRAG_NONE) begin
            out_item_next.verdict = ipv4rf_pkg::VERDICT_FRAGMENT;
        end else begin
            out_item_next.verdict        = ipv4rf_pkg::VERDICT_ACCEPT;
            out_item_next.payload_length = pop_data.total_length - hdr_len16;
        end
    end

    // Hold the local address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_addr_reg <= '0;
        end else if (cfg_we) begin
            local_addr_reg <= cfg_wdata;
        end
    end

    // Output register: load on pop, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop_ready) begin
            out_valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_ready && pop_valid) begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

@@ design/ipv4_receive_filter.sv @@
// IPv4 receive filter.
// Input channel (s_valid/s_ready/s_item): one Ethernet frame byte per item,
// wire order, with last_byte set on the final byte of each frame.
// Result channel (m_valid/m_ready/m_item): one verdict item per frame, with
// protocol, header length, payload length and both addresses.
// Configuration: cfg_we writes cfg_wdata into the local address at once;
// write it only while no frame is in flight.
// Throughput: one byte per clock while s_ready is high, frames back to back with no gap. The
// front end captures fields and adds header words as bytes stream in.
// Result path: the last byte's frame summary is written into the frame queue and
// then loaded into the checker's output register, where the result appears.
// Stall: while m_ready is low the output register holds its item; the
// queue absorbs up to QUEUE_DEPTH further frame summaries, after which
// s_ready falls until the receiver takes an item.
// Reset (aresetn low at a clock edge) clears the byte count, captured
// fields, queue and output valid, and sets the local address to zero.
module ipv4_receive_filter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [31:0]            cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ipv4rf_pkg::in_item_t   s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ipv4rf_pkg::out_item_t  m_item
);

    logic                   push_valid;
    logic                   push_ready;
    ipv4rf_pkg::frame_sum_t push_data;
    logic                   pop_valid;
    logic                   pop_ready;
    ipv4rf_pkg::frame_sum_t pop_data;

    ipv4rf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    ipv4rf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data)
    );

    ipv4rf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    // No result straight out of reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Payload length is reported only for accepted frames
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.verdict != ipv4rf_pkg::VERDICT_ACCEPT
            |-> m_item.payload_length == 16'd0)
        else $error("payload length on a rejected frame");

    // An accepted frame has a full header whose length is a multiple of four bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.verdict == ipv4rf_pkg::VERDICT_ACCEPT
            |-> m_item.header_length >= 6'd20
                && m_item.header_length[1:0] == 2'b00)
        else $error("accepted frame with a short header");

    // A frame summary cannot be queued while the front end is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> !(push_valid && push_ready))
        else $error("frame queued while input stalled");

endmodule
